// ===== rtl/system_timer_compare_peripheral_macros.svh =====
// Assertion macros shared by the timer/compare RTL.
`ifndef SYSTEM_TIMER_COMPARE_PERIPHERAL_MACROS_SVH
`define SYSTEM_TIMER_COMPARE_PERIPHERAL_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define STCP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("timer/compare assertion failed");

// Next-cycle implication, disabled while reset is low.
`define STCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("timer/compare assertion failed");

`endif

// ===== rtl/stcp_pkg.sv =====
// Types, register codes and constants of the timer/compare block.
package stcp_pkg;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } mode_e;

  typedef enum logic [4:0] {
    REG_CLC     = 5'd0,
    REG_ID      = 5'd1,
    REG_TIM0    = 5'd2,
    REG_TIM1    = 5'd3,
    REG_TIM2    = 5'd4,
    REG_TIM3    = 5'd5,
    REG_TIM4    = 5'd6,
    REG_TIM5    = 5'd7,
    REG_TIM6    = 5'd8,
    REG_CAP     = 5'd9,
    REG_CMP0    = 5'd10,
    REG_CMP1    = 5'd11,
    REG_CMCON   = 5'd12,
    REG_ICR     = 5'd13,
    REG_ISCR    = 5'd14,
    REG_OCS     = 5'd15,
    REG_TIM0SV  = 5'd16,
    REG_CAPSV   = 5'd17,
    REG_KRSTCLR = 5'd18,
    REG_KRST1   = 5'd19,
    REG_KRST0   = 5'd20,
    REG_ACCEN1  = 5'd21,
    REG_ACCEN0  = 5'd22
  } reg_e;

  localparam logic [31:0] TIMER_ID_VALUE = 32'h0000_00C0;
  localparam logic [31:0] CMCON_RESET  = 32'h001F_0000 | 32'h0000_001F;
  localparam logic [31:0] ACCEN_RESET  = 32'hFFFF_FFFF;
  localparam logic [1:0]  KRST_STATUS_DONE = 2'h2;

  // ICR bit positions
  localparam int unsigned ICR_CMP0EN = 0;
  localparam int unsigned ICR_CMP0IR = 1;
  localparam int unsigned ICR_CMP0OS = 2;
  localparam int unsigned ICR_CMP1EN = 4;
  localparam int unsigned ICR_CMP1IR = 5;
  localparam int unsigned ICR_CMP1OS = 6;
  localparam logic [6:0]  ICR_CTL_MASK = 7'h55;

  // ISCR bit positions
  localparam int unsigned ISCR_SET0 = 0;
  localparam int unsigned ISCR_CLR0 = 1;
  localparam int unsigned ISCR_SET1 = 4;
  localparam int unsigned ISCR_CLR1 = 5;

  typedef struct packed {
    logic [1:0]  mode;
    logic [4:0]  reg_index;
    logic [31:0] write_data;
    logic [31:0] tick_cycles;
  } item_t;

  // Field selection and reference value of one compare channel
  typedef struct packed {
    logic [4:0]  start;
    logic [4:0]  size;
    logic [31:0] value;
  } cmp_cfg_t;

endpackage

// ===== rtl/stcp_if.sv =====
// Valid/ready channel interfaces for the timer/compare requests and responses.
interface stcp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [4:0]  reg_index;
  logic [31:0] write_data;
  logic [31:0] tick_cycles;

  modport source (output valid, mode, reg_index, write_data, tick_cycles, input ready);
  modport sink   (input valid, mode, reg_index, write_data, tick_cycles, output ready);
endinterface

interface stcp_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq0_pending;
  logic        irq1_pending;

  modport source (output valid, read_data, irq0_pending, irq1_pending, input ready);
  modport sink   (input valid, read_data, irq0_pending, irq1_pending, output ready);
endinterface

// ===== rtl/stcp_cmp.sv =====
// Field compare of one channel: equality edge, crossing or wrap past the value.
module stcp_cmp (
  input  stcp_pkg::cmp_cfg_t cfg_i,
  input  logic [63:0]        old_i,
  input  logic [63:0]        new_i,
  output logic               hit_o
);

  logic [31:0] mask;
  logic [31:0] old_f;
  logic [31:0] new_f;
  logic [31:0] cmp_f;

  // size 31 shifts every one out, leaving the full mask
  assign mask  = ~(32'hFFFF_FFFE << cfg_i.size);
  assign old_f = 32'(old_i >> cfg_i.start) & mask;
  assign new_f = 32'(new_i >> cfg_i.start) & mask;
  assign cmp_f = cfg_i.value & mask;

  assign hit_o = ((new_f == cmp_f) && (old_f != cmp_f)) ||
                 ((old_f < cmp_f) && (new_f >= cmp_f)) ||
                 ((new_f < old_f) && (cmp_f <= new_f));

endmodule

// ===== rtl/system_timer_compare_peripheral.sv =====
// Top level of the 64-bit timer with two field compares and a register file.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+------------------------------------------
//  req_i   | in  | valid/ready           | mode, reg_index, write_data, tick_cycles
//  rsp_o   | out | valid/ready           | read_data, irq0_pending, irq1_pending
//
//  One transaction per cycle while rsp_o is not stalled: the item goes from the input
//  register through one pass of 64-bit add, field compare and read mux into the response
//  register; the timer state is written at the same edge.
//  A stalled response holds the input register; req_i.ready drops only then.
//  rst_ni clears the control and timer state asynchronously, but not the item and read
//  data registers; an armed KRST0 write resets the timer registers and leaves status 2 behind.
module system_timer_compare_peripheral (
  input  logic clk_i,
  input  logic rst_ni,
  stcp_req_if.sink   req_i,
  stcp_rsp_if.source rsp_o
);

`include "system_timer_compare_peripheral_macros.svh"

  // Input register
  logic                s_valid_q;
  stcp_pkg::item_t     s_item_q;
  logic                adv;   // input register moves into the response register
  logic                fire;  // item in the input register is executed this cycle

  // Response register
  logic        r_valid_q;
  logic [31:0] r_data_q;
  logic [31:0] r_data_d;

  // Timer state
  logic [63:0] count_q, count_d;
  logic [63:0] cap_q, cap_d;
  logic [31:0] cmp0_q, cmp0_d;
  logic [31:0] cmp1_q, cmp1_d;
  logic [31:0] cmcon_q, cmcon_d;
  logic [6:0]  icr_q, icr_d;
  logic [31:0] clc_q, clc_d;
  logic [31:0] ocs_q, ocs_d;
  logic [1:0]  krst_st_q, krst_st_d;
  logic        krst_arm_q, krst_arm_d;
  logic [31:0] accen0_q, accen0_d;
  logic [31:0] accen1_q, accen1_d;

  logic [63:0]        count_sum;
  stcp_pkg::cmp_cfg_t cfg0, cfg1;
  logic               hit0, hit1;
  logic               do_tick;
  logic               ir0_set_ev;

  assign adv         = !r_valid_q || rsp_o.ready;
  assign fire        = s_valid_q && adv;
  assign req_i.ready = !s_valid_q || adv;

  // Capture the transaction; hold it while the response side stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s_item_q.mode        <= req_i.mode;
      s_item_q.reg_index   <= req_i.reg_index;
      s_item_q.write_data  <= req_i.write_data;
      s_item_q.tick_cycles <= req_i.tick_cycles;
    end
  end

  // Compare channels look at the counter before and after the add.
  assign count_sum  = count_q + {32'h0, s_item_q.tick_cycles};
  assign cfg0.start = cmcon_q[12:8];
  assign cfg0.size  = cmcon_q[4:0];
  assign cfg0.value = cmp0_q;
  assign cfg1.start = cmcon_q[28:24];
  assign cfg1.size  = cmcon_q[20:16];
  assign cfg1.value = cmp1_q;

  stcp_cmp u_cmp0 (.cfg_i(cfg0), .old_i(count_q), .new_i(count_sum), .hit_o(hit0));
  stcp_cmp u_cmp1 (.cfg_i(cfg1), .old_i(count_q), .new_i(count_sum), .hit_o(hit1));

  // Counting stops while CLC bit 0 is set.
  assign do_tick = fire && (s_item_q.mode == stcp_pkg::MODE_TICK) && !clc_q[0];

  // Next state and read data for the item in the input register.
  always_comb begin
    count_d    = count_q;
    cap_d      = cap_q;
    cmp0_d     = cmp0_q;
    cmp1_d     = cmp1_q;
    cmcon_d    = cmcon_q;
    icr_d      = icr_q;
    clc_d      = clc_q;
    ocs_d      = ocs_q;
    krst_st_d  = krst_st_q;
    krst_arm_d = krst_arm_q;
    accen0_d   = accen0_q;
    accen1_d   = accen1_q;
    r_data_d   = 32'h0;

    if (fire) begin
      case (s_item_q.mode)
        stcp_pkg::MODE_TICK: begin
          if (!clc_q[0]) begin
            count_d = count_sum;
            if (icr_q[stcp_pkg::ICR_CMP0EN] && hit0) icr_d[stcp_pkg::ICR_CMP0IR] = 1'b1;
            if (icr_q[stcp_pkg::ICR_CMP1EN] && hit1) icr_d[stcp_pkg::ICR_CMP1IR] = 1'b1;
          end
        end
        stcp_pkg::MODE_READ: begin
          case (s_item_q.reg_index)
            stcp_pkg::REG_CLC:    r_data_d = clc_q;
            stcp_pkg::REG_ID:     r_data_d = stcp_pkg::TIMER_ID_VALUE;
            stcp_pkg::REG_TIM0: begin
              r_data_d = count_q[31:0];
              cap_d    = count_q;
            end
            stcp_pkg::REG_TIM1:   r_data_d = count_q[35:4];
            stcp_pkg::REG_TIM2:   r_data_d = count_q[39:8];
            stcp_pkg::REG_TIM3:   r_data_d = count_q[43:12];
            stcp_pkg::REG_TIM4:   r_data_d = count_q[47:16];
            stcp_pkg::REG_TIM5:   r_data_d = count_q[51:20];
            stcp_pkg::REG_TIM6:   r_data_d = cap_q[63:32];
            stcp_pkg::REG_CAP:    r_data_d = cap_q[31:0];
            stcp_pkg::REG_CMP0:   r_data_d = cmp0_q;
            stcp_pkg::REG_CMP1:   r_data_d = cmp1_q;
            stcp_pkg::REG_CMCON:  r_data_d = cmcon_q;
            stcp_pkg::REG_ICR:    r_data_d = {25'h0, icr_q};
            stcp_pkg::REG_OCS:    r_data_d = ocs_q;
            stcp_pkg::REG_KRST1:  r_data_d = {31'h0, krst_arm_q};
            stcp_pkg::REG_KRST0:  r_data_d = {30'h0, krst_st_q};
            stcp_pkg::REG_ACCEN1: r_data_d = accen1_q;
            stcp_pkg::REG_ACCEN0: r_data_d = accen0_q;
            default:              r_data_d = 32'h0;
          endcase
        end
        stcp_pkg::MODE_WRITE: begin
          case (s_item_q.reg_index)
            stcp_pkg::REG_CLC:   clc_d   = s_item_q.write_data;
            stcp_pkg::REG_CMP0:  cmp0_d  = s_item_q.write_data;
            stcp_pkg::REG_CMP1:  cmp1_d  = s_item_q.write_data;
            stcp_pkg::REG_CMCON: cmcon_d = s_item_q.write_data;
            stcp_pkg::REG_ICR: begin
              // keep the request flags, take enables and output selects
              icr_d = (icr_q & ~stcp_pkg::ICR_CTL_MASK) |
                      (s_item_q.write_data[6:0] & stcp_pkg::ICR_CTL_MASK);
            end
            stcp_pkg::REG_ISCR: begin
              // clear wins over set
              if (s_item_q.write_data[stcp_pkg::ISCR_SET0]) icr_d[stcp_pkg::ICR_CMP0IR] = 1'b1;
              if (s_item_q.write_data[stcp_pkg::ISCR_SET1]) icr_d[stcp_pkg::ICR_CMP1IR] = 1'b1;
              if (s_item_q.write_data[stcp_pkg::ISCR_CLR0]) icr_d[stcp_pkg::ICR_CMP0IR] = 1'b0;
              if (s_item_q.write_data[stcp_pkg::ISCR_CLR1]) icr_d[stcp_pkg::ICR_CMP1IR] = 1'b0;
            end
            stcp_pkg::REG_OCS:     ocs_d = s_item_q.write_data;
            stcp_pkg::REG_KRSTCLR: begin
              if (s_item_q.write_data[0]) krst_st_d[1] = 1'b0;
            end
            stcp_pkg::REG_KRST1:   krst_arm_d = s_item_q.write_data[0];
            stcp_pkg::REG_KRST0: begin
              // armed kernel reset: return every register but the status to its reset value; status becomes done
              if (s_item_q.write_data[0] && krst_arm_q) begin
                count_d    = 64'h0;
                cap_d      = 64'h0;
                cmp0_d     = 32'h0;
                cmp1_d     = 32'h0;
                cmcon_d    = stcp_pkg::CMCON_RESET;
                icr_d      = 7'h0;
                clc_d      = 32'h0;
                ocs_d      = 32'h0;
                krst_st_d  = stcp_pkg::KRST_STATUS_DONE;
                krst_arm_d = 1'b0;
                accen0_d   = stcp_pkg::ACCEN_RESET;
                accen1_d   = stcp_pkg::ACCEN_RESET;
              end
            end
            stcp_pkg::REG_ACCEN1: accen1_d = s_item_q.write_data;
            stcp_pkg::REG_ACCEN0: accen0_d = s_item_q.write_data;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= 64'h0;
      cap_q      <= 64'h0;
      cmp0_q     <= 32'h0;
      cmp1_q     <= 32'h0;
      cmcon_q    <= stcp_pkg::CMCON_RESET;
      icr_q      <= 7'h0;
      clc_q      <= 32'h0;
      ocs_q      <= 32'h0;
      krst_st_q  <= 2'h0;
      krst_arm_q <= 1'b0;
      accen0_q   <= stcp_pkg::ACCEN_RESET;
      accen1_q   <= stcp_pkg::ACCEN_RESET;
    end else begin
      count_q    <= count_d;
      cap_q      <= cap_d;
      cmp0_q     <= cmp0_d;
      cmp1_q     <= cmp1_d;
      cmcon_q    <= cmcon_d;
      icr_q      <= icr_d;
      clc_q      <= clc_d;
      ocs_q      <= ocs_d;
      krst_st_q  <= krst_st_d;
      krst_arm_q <= krst_arm_d;
      accen0_q   <= accen0_d;
      accen1_q   <= accen1_d;
    end
  end

  // Response register: load on execute, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else if (adv) begin
      r_valid_q <= s_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      r_data_q <= r_data_d;
    end
  end

  // Flags after the item come straight from ICR, which only moves on execute.
  assign rsp_o.valid        = r_valid_q;
  assign rsp_o.read_data    = r_data_q;
  assign rsp_o.irq0_pending = icr_q[stcp_pkg::ICR_CMP0IR];
  assign rsp_o.irq1_pending = icr_q[stcp_pkg::ICR_CMP1IR];

  assign ir0_set_ev = (do_tick && icr_q[stcp_pkg::ICR_CMP0EN] && hit0) ||
                      (fire && (s_item_q.mode == stcp_pkg::MODE_WRITE) &&
                       (s_item_q.reg_index == stcp_pkg::REG_ISCR) &&
                       s_item_q.write_data[stcp_pkg::ISCR_SET0]);

  `STCP_ASSERT_NEXT(a_count_idle, clk_i, rst_ni, !fire, $stable(count_q))
  `STCP_ASSERT_NEXT(a_count_gated, clk_i, rst_ni,
                    fire && (s_item_q.mode == stcp_pkg::MODE_TICK) && clc_q[0],
                    $stable(count_q))
  `STCP_ASSERT_SAME(a_ir0_source, clk_i, rst_ni,
                    $rose(icr_q[stcp_pkg::ICR_CMP0IR]), $past(ir0_set_ev))
  `STCP_ASSERT_SAME(a_rsp_source, clk_i, rst_ni, $rose(r_valid_q), $past(fire))

endmodule
